>>> design/position_calibration_sequencer_assert.svh
// assertion macros of the position calibration sequencer, used by the pcs_ctrl module
`ifndef POSITION_CALIBRATION_SEQUENCER_ASSERT_SVH
`define POSITION_CALIBRATION_SEQUENCER_ASSERT_SVH

// condition that holds at every clock edge out of reset
`define PCS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define PCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/pcs_pkg.sv
// types, codes and helpers of the position calibration sequencer
package pcs_pkg;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 80;
    localparam int WORD_W      = 16;
    localparam int CMD_W       = 3;
    localparam int PHASE_W     = 2;

    localparam logic [WORD_W-1:0] UNSET_WORD = 16'hFFFF;
    localparam longint WORD_MAX = 64'd65535;

    // led commands
    localparam logic [CMD_W-1:0] CMD_NONE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ON    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_OFF   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_BLINK = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ALARM = 3'd4;

    // phases while calibrating
    localparam logic [PHASE_W-1:0] PH_START_WAIT = 2'd0;
    localparam logic [PHASE_W-1:0] PH_CAPTURE    = 2'd1;
    localparam logic [PHASE_W-1:0] PH_END_WAIT   = 2'd2;
    localparam logic [PHASE_W-1:0] PH_UNUSED     = 2'd3;

    typedef struct packed {
        logic              open_pressed;
        logic              open_long;
        logic              close_pressed;
        logic              close_long;
        logic [WORD_W-1:0] position;
        logic [WORD_W-1:0] turn_count;
    } item_t;

    typedef struct packed {
        logic [CMD_W-1:0]  led_one_cmd;
        logic [CMD_W-1:0]  led_five_cmd;
        logic              blink_all_once;
        logic              relay_drive;
        logic              store_write;
        logic              restart_request;
        logic              cal_active;
        logic [WORD_W-1:0] open_value;
        logic [WORD_W-1:0] close_value;
        logic [WORD_W-1:0] open_turns;
        logic [WORD_W-1:0] close_turns;
    } result_t;

    // bits of the linear value turn_count * rev + position
    function automatic int lin_width(input int rev);
        return $clog2(WORD_MAX * longint'(rev + 1) + 64'd1);
    endfunction

endpackage

>>> design/pcs_in_stage.sv
// input register: holds one word and its linear encoder value
module pcs_in_stage #(
    parameter int REVOLUTION_SIZE = 4096
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            s_tvalid,
    output logic                                            s_tready,
    input  logic [pcs_pkg::IN_TDATA_W-1:0]                  s_tdata,
    input  logic                                            advance,
    output logic                                            item_valid,
    output pcs_pkg::item_t                                  item,
    output logic [pcs_pkg::lin_width(REVOLUTION_SIZE)-1:0]  cur_lin
);
    localparam int LIN_W = pcs_pkg::lin_width(REVOLUTION_SIZE);

    logic                 vld_reg, vld_next;
    pcs_pkg::item_t       item_reg, item_next;
    logic [LIN_W-1:0]     lin_reg, lin_next;
    logic                 load;

    assign s_tready = !vld_reg || advance;
    assign load     = s_tvalid && s_tready;

    always_comb begin
        item_next.open_pressed  = s_tdata[0];
        item_next.open_long     = s_tdata[1];
        item_next.close_pressed = s_tdata[2];
        item_next.close_long    = s_tdata[3];
        item_next.position      = s_tdata[19:4];
        item_next.turn_count    = s_tdata[35:20];
        lin_next = LIN_W'(s_tdata[35:20]) * LIN_W'(REVOLUTION_SIZE)
                 + LIN_W'(s_tdata[19:4]);
        if (load) begin
            vld_next = 1'b1;
        end else if (advance) begin
            vld_next = 1'b0;
        end else begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= item_next;
            lin_reg  <= lin_next;
        end
    end

    assign item_valid = vld_reg;
    assign item       = item_reg;
    assign cur_lin    = lin_reg;
endmodule

>>> design/pcs_ctrl.sv
// calibration sequencer state and the per-word decisions
module pcs_ctrl #(
    parameter int REVOLUTION_SIZE = 4096
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            fire,
    input  pcs_pkg::item_t                                  item,
    input  logic [pcs_pkg::lin_width(REVOLUTION_SIZE)-1:0]  cur_lin,
    output pcs_pkg::result_t                                result
);
    localparam int LIN_W = pcs_pkg::lin_width(REVOLUTION_SIZE);
    localparam logic signed [LIN_W:0] SPAN_MAX = (LIN_W+1)'(REVOLUTION_SIZE);
    localparam logic signed [LIN_W:0] SPAN_MIN = -SPAN_MAX;

    logic                          active_reg, active_next;
    logic [pcs_pkg::PHASE_W-1:0]   phase_reg, phase_next;
    logic [1:0]                    capt_reg, capt_next;
    logic                          relay_reg, relay_next;
    logic [pcs_pkg::WORD_W-1:0]    open_val_reg, open_val_next;
    logic [pcs_pkg::WORD_W-1:0]    close_val_reg, close_val_next;
    logic [pcs_pkg::WORD_W-1:0]    open_trn_reg, open_trn_next;
    logic [pcs_pkg::WORD_W-1:0]    close_trn_reg, close_trn_next;
    logic [LIN_W-1:0]              lo_lin_reg, lo_lin_next;
    logic [LIN_W-1:0]              hi_lin_reg, hi_lin_next;
    logic [pcs_pkg::WORD_W-1:0]    pub_open_val_reg, pub_open_val_next;
    logic [pcs_pkg::WORD_W-1:0]    pub_close_val_reg, pub_close_val_next;
    logic [pcs_pkg::WORD_W-1:0]    pub_open_trn_reg, pub_open_trn_next;
    logic [pcs_pkg::WORD_W-1:0]    pub_close_trn_reg, pub_close_trn_next;

    logic             in_capture, cap_open, cap_close;
    logic [1:0]       capt_sel;
    logic [LIN_W-1:0] lo_sel, hi_sel, op_a, op_b;
    logic             span_ok;
    logic signed [LIN_W:0] span_diff;

    // endpoint captures of this word, seen by the span check
    assign in_capture = active_reg && (phase_reg == pcs_pkg::PH_CAPTURE);
    assign cap_close  = in_capture && item.close_long && !item.open_pressed;
    assign cap_open   = in_capture && item.open_long && !item.close_pressed;
    assign capt_sel   = capt_reg | {cap_close, cap_open};
    assign lo_sel     = cap_open  ? cur_lin : lo_lin_reg;
    assign hi_sel     = cap_close ? cur_lin : hi_lin_reg;

    always_comb begin
        case (capt_sel)
            2'b11: begin
                op_a = hi_sel;
                op_b = lo_sel;
            end
            2'b01: begin
                op_a = lo_sel;
                op_b = cur_lin;
            end
            2'b10: begin
                op_a = hi_sel;
                op_b = cur_lin;
            end
            default: begin
                op_a = cur_lin;
                op_b = cur_lin;
            end
        endcase
    end

    assign span_diff = $signed({1'b0, op_a}) - $signed({1'b0, op_b});
    assign span_ok   = (span_diff < SPAN_MAX) && (span_diff > SPAN_MIN);

    always_comb begin
        active_next        = active_reg;
        phase_next         = phase_reg;
        capt_next          = capt_reg;
        relay_next         = relay_reg;
        open_val_next      = cap_open  ? item.position   : open_val_reg;
        open_trn_next      = cap_open  ? item.turn_count : open_trn_reg;
        close_val_next     = cap_close ? item.position   : close_val_reg;
        close_trn_next     = cap_close ? item.turn_count : close_trn_reg;
        lo_lin_next        = lo_sel;
        hi_lin_next        = hi_sel;
        pub_open_val_next  = pub_open_val_reg;
        pub_close_val_next = pub_close_val_reg;
        pub_open_trn_next  = pub_open_trn_reg;
        pub_close_trn_next = pub_close_trn_reg;

        result.led_one_cmd     = pcs_pkg::CMD_NONE;
        result.led_five_cmd    = pcs_pkg::CMD_NONE;
        result.blink_all_once  = 1'b0;
        result.store_write     = 1'b0;
        result.restart_request = 1'b0;

        if (!active_reg) begin
            if (item.open_long && item.close_long) begin
                active_next         = 1'b1;
                phase_next          = pcs_pkg::PH_START_WAIT;
                result.led_one_cmd  = pcs_pkg::CMD_ON;
                result.led_five_cmd = pcs_pkg::CMD_ON;
                open_val_next       = pcs_pkg::UNSET_WORD;
                close_val_next      = pcs_pkg::UNSET_WORD;
                open_trn_next       = pcs_pkg::UNSET_WORD;
                close_trn_next      = pcs_pkg::UNSET_WORD;
                relay_next          = 1'b1;
                capt_next           = 2'b00;
            end
        end else begin
            case (phase_reg)
                pcs_pkg::PH_START_WAIT: begin
                    result.led_one_cmd  = pcs_pkg::CMD_BLINK;
                    result.led_five_cmd = pcs_pkg::CMD_BLINK;
                    if (!item.open_pressed && !item.close_pressed) begin
                        phase_next = pcs_pkg::PH_CAPTURE;
                    end
                end
                pcs_pkg::PH_CAPTURE: begin
                    capt_next = capt_sel;
                    if (span_ok) begin
                        result.led_one_cmd  = capt_sel[0] ? pcs_pkg::CMD_ON
                                                          : pcs_pkg::CMD_BLINK;
                        result.led_five_cmd = capt_sel[1] ? pcs_pkg::CMD_ON
                                                          : pcs_pkg::CMD_BLINK;
                        if (item.open_long && item.close_long) begin
                            if (capt_sel == 2'b11) begin
                                pub_open_val_next  = open_val_next;
                                pub_close_val_next = close_val_next;
                                pub_open_trn_next  = open_trn_next;
                                pub_close_trn_next = close_trn_next;
                                result.store_write = 1'b1;
                            end
                            phase_next            = pcs_pkg::PH_END_WAIT;
                            result.blink_all_once = 1'b1;
                        end
                    end else begin
                        result.led_one_cmd  = pcs_pkg::CMD_ALARM;
                        result.led_five_cmd = pcs_pkg::CMD_ALARM;
                    end
                end
                pcs_pkg::PH_END_WAIT: begin
                    if (!item.open_pressed && !item.close_pressed) begin
                        result.led_one_cmd     = pcs_pkg::CMD_OFF;
                        result.led_five_cmd    = pcs_pkg::CMD_OFF;
                        active_next            = 1'b0;
                        relay_next             = 1'b0;
                        result.restart_request = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        result.relay_drive = relay_next;
        result.cal_active  = active_next;
        result.open_value  = pub_open_val_next;
        result.close_value = pub_close_val_next;
        result.open_turns  = pub_open_trn_next;
        result.close_turns = pub_close_trn_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg        <= 1'b0;
            phase_reg         <= pcs_pkg::PH_START_WAIT;
            capt_reg          <= 2'b11;
            relay_reg         <= 1'b0;
            pub_open_val_reg  <= pcs_pkg::UNSET_WORD;
            pub_close_val_reg <= pcs_pkg::UNSET_WORD;
            pub_open_trn_reg  <= pcs_pkg::UNSET_WORD;
            pub_close_trn_reg <= pcs_pkg::UNSET_WORD;
        end else if (fire) begin
            active_reg        <= active_next;
            phase_reg         <= phase_next;
            capt_reg          <= capt_next;
            relay_reg         <= relay_next;
            pub_open_val_reg  <= pub_open_val_next;
            pub_close_val_reg <= pub_close_val_next;
            pub_open_trn_reg  <= pub_open_trn_next;
            pub_close_trn_reg <= pub_close_trn_next;
        end
    end

    // endpoint values are only read once captured since entry
    always_ff @(posedge aclk) begin
        if (fire) begin
            open_val_reg  <= open_val_next;
            close_val_reg <= close_val_next;
            open_trn_reg  <= open_trn_next;
            close_trn_reg <= close_trn_next;
            lo_lin_reg    <= lo_lin_next;
            hi_lin_reg    <= hi_lin_next;
        end
    end

`include "position_calibration_sequencer_assert.svh"

    `PCS_ASSERT_ALWAYS(a_relay_follows_active, relay_reg == active_reg,
                       "relay out of step")
    `PCS_ASSERT_ALWAYS(a_no_unused_phase, phase_reg != pcs_pkg::PH_UNUSED,
                       "unused phase")
    `PCS_ASSERT_NEXT(a_entry_clears,
                     fire && !active_reg && item.open_long && item.close_long,
                     active_reg && capt_reg == 2'b00 && phase_reg == pcs_pkg::PH_START_WAIT,
                     "entry did not clear captures")
    `PCS_ASSERT_NEXT(a_restart_idles, fire && result.restart_request,
                     !active_reg && !relay_reg, "still active after restart")
endmodule

>>> design/pcs_out_stage.sv
// result register on the master side
module pcs_out_stage (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            load,
    input  pcs_pkg::result_t                result,
    output logic                            can_load,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pcs_pkg::OUT_TDATA_W-1:0] m_tdata
);
    logic                            vld_reg, vld_next;
    logic [pcs_pkg::OUT_TDATA_W-1:0] data_reg, data_next;

    assign can_load = !vld_reg || m_tready;

    always_comb begin
        data_next = {5'd0,
                     result.close_turns,
                     result.open_turns,
                     result.close_value,
                     result.open_value,
                     result.cal_active,
                     result.restart_request,
                     result.store_write,
                     result.relay_drive,
                     result.blink_all_once,
                     result.led_five_cmd,
                     result.led_one_cmd};
        if (load) begin
            vld_next = 1'b1;
        end else if (m_tready) begin
            vld_next = 1'b0;
        end else begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = data_reg;
endmodule

>>> design/position_calibration_sequencer.sv
// top level of the position calibration sequencer
// One word in per clock, one result word out for each word in. A word is held in
// the input register (where its linear encoder value turn_count * REVOLUTION_SIZE
// + position is formed), then one pass of compare logic updates the calibration
// state and loads the result register, from which the result is offered on the
// master side. The rate is one word per clock, set by that single pass; a stall
// on the master side holds both registers and back-pressures the slave side.
module position_calibration_sequencer #(
    parameter int REVOLUTION_SIZE = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // open_pressed, open_long, close_pressed, close_long, position[16], turn_count[16]
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // led_one_cmd[3], led_five_cmd[3], blink_all_once, relay_drive, store_write,
    // restart_request, cal_active, open_value[16], close_value[16],
    // open_turns[16], close_turns[16]
    output logic [79:0] m_tdata
);
    localparam int LIN_W = pcs_pkg::lin_width(REVOLUTION_SIZE);

    logic             item_valid;
    pcs_pkg::item_t   item;
    logic [LIN_W-1:0] cur_lin;
    pcs_pkg::result_t result;
    logic             can_load;
    logic             fire;

    assign fire = item_valid && can_load;

    pcs_in_stage #(
        .REVOLUTION_SIZE(REVOLUTION_SIZE)
    ) u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (can_load),
        .item_valid (item_valid),
        .item       (item),
        .cur_lin    (cur_lin)
    );

    pcs_ctrl #(
        .REVOLUTION_SIZE(REVOLUTION_SIZE)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item),
        .cur_lin (cur_lin),
        .result  (result)
    );

    pcs_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .result   (result),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );
endmodule

>>> sim/tb_position_calibration_sequencer.sv
// testbench for the position calibration sequencer: directed and random button sessions
module tb_position_calibration_sequencer;

    localparam int REVOLUTION_SIZE = 4096;
    localparam int RANDOM_ITEMS    = 1750;
    localparam int STALL_LIMIT     = 4000;
    localparam int HOLD_CYCLES     = 80;
    localparam int DRAIN_CYCLES    = 8;
    // highest linear base that still leaves room for the widest offset
    localparam int unsigned BASE_MAX = 65535 * REVOLUTION_SIZE + REVOLUTION_SIZE - 1 - 10000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;

    position_calibration_sequencer #(
        .REVOLUTION_SIZE(REVOLUTION_SIZE)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // predicted calibration state
    logic                        cal_on;
    logic [pcs_pkg::PHASE_W-1:0] cal_phase;
    logic [pcs_pkg::WORD_W-1:0]  pend_open_val, pend_close_val;
    logic [pcs_pkg::WORD_W-1:0]  pend_open_turns, pend_close_turns;
    logic                        got_open, got_close;
    logic [pcs_pkg::WORD_W-1:0]  pub_open_val, pub_close_val;
    logic [pcs_pkg::WORD_W-1:0]  pub_open_turns, pub_close_turns;
    logic                        relays_on;

    pcs_pkg::result_t expected_results[$];
    int unsigned errors        = 0;
    int unsigned ticks_sent    = 0;
    int unsigned sessions_run  = 0;
    int unsigned stores_seen   = 0;
    int unsigned restarts_seen = 0;
    int unsigned alarms_seen   = 0;
    int unsigned idle_cycles   = 0;
    int          burst_left    = 0;
    bit          gaps_on       = 1'b1;
    int          hold_requests = 0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    task automatic clear_model();
        cal_on           = 1'b0;
        cal_phase        = pcs_pkg::PH_START_WAIT;
        pend_open_val    = pcs_pkg::UNSET_WORD;
        pend_close_val   = pcs_pkg::UNSET_WORD;
        pend_open_turns  = pcs_pkg::UNSET_WORD;
        pend_close_turns = pcs_pkg::UNSET_WORD;
        got_open         = 1'b1;
        got_close        = 1'b1;
        pub_open_val     = pcs_pkg::UNSET_WORD;
        pub_close_val    = pcs_pkg::UNSET_WORD;
        pub_open_turns   = pcs_pkg::UNSET_WORD;
        pub_close_turns  = pcs_pkg::UNSET_WORD;
        relays_on        = 1'b0;
    endtask

    function automatic longint unsigned linear_reading(
        input logic [pcs_pkg::WORD_W-1:0] trn,
        input logic [pcs_pkg::WORD_W-1:0] pos);
        return 64'(trn) * 64'(REVOLUTION_SIZE) + 64'(pos);
    endfunction

    function automatic bit under_one_rev(input longint unsigned a, input longint unsigned b);
        longint unsigned d;
        d = (a >= b) ? a - b : b - a;
        return d < 64'(REVOLUTION_SIZE);
    endfunction

    function automatic bit span_fits(input logic [pcs_pkg::WORD_W-1:0] pos,
                                     input logic [pcs_pkg::WORD_W-1:0] trn);
        longint unsigned cur, lo, hi;
        cur = linear_reading(trn, pos);
        lo  = linear_reading(pend_open_turns, pend_open_val);
        hi  = linear_reading(pend_close_turns, pend_close_val);
        if (!got_open && !got_close) begin
            return 1'b1;
        end else if (got_open && !got_close) begin
            return under_one_rev(lo, cur);
        end else if (!got_open && got_close) begin
            return under_one_rev(hi, cur);
        end
        return under_one_rev(hi, lo);
    endfunction

    // advances the predicted state by one tick and returns its result word
    function automatic pcs_pkg::result_t predict_tick(input logic [39:0] w);
        logic                       op, ol, cp, cl;
        logic [pcs_pkg::WORD_W-1:0] pos, trn;
        pcs_pkg::result_t           r;
        op  = w[0];
        ol  = w[1];
        cp  = w[2];
        cl  = w[3];
        pos = w[19:4];
        trn = w[35:20];
        r   = '0;
        r.led_one_cmd  = pcs_pkg::CMD_NONE;
        r.led_five_cmd = pcs_pkg::CMD_NONE;
        if (!cal_on) begin
            if (ol && cl) begin
                cal_on           = 1'b1;
                cal_phase        = pcs_pkg::PH_START_WAIT;
                r.led_one_cmd    = pcs_pkg::CMD_ON;
                r.led_five_cmd   = pcs_pkg::CMD_ON;
                pend_open_val    = pcs_pkg::UNSET_WORD;
                pend_close_val   = pcs_pkg::UNSET_WORD;
                pend_open_turns  = pcs_pkg::UNSET_WORD;
                pend_close_turns = pcs_pkg::UNSET_WORD;
                relays_on        = 1'b1;
                got_open         = 1'b0;
                got_close        = 1'b0;
            end
        end else if (cal_phase == pcs_pkg::PH_START_WAIT) begin
            r.led_one_cmd  = pcs_pkg::CMD_BLINK;
            r.led_five_cmd = pcs_pkg::CMD_BLINK;
            if (!op && !cp)
                cal_phase = pcs_pkg::PH_CAPTURE;
        end else if (cal_phase == pcs_pkg::PH_CAPTURE) begin
            if (cl && !op) begin
                pend_close_val   = pos;
                pend_close_turns = trn;
                got_close        = 1'b1;
            end
            if (ol && !cp) begin
                pend_open_val   = pos;
                pend_open_turns = trn;
                got_open        = 1'b1;
                r.led_one_cmd   = pcs_pkg::CMD_ON;
            end
            if (span_fits(pos, trn)) begin
                r.led_one_cmd  = got_open ? pcs_pkg::CMD_ON : pcs_pkg::CMD_BLINK;
                r.led_five_cmd = got_close ? pcs_pkg::CMD_ON : pcs_pkg::CMD_BLINK;
                if (ol && cl) begin
                    if (got_open && got_close) begin
                        pub_open_val    = pend_open_val;
                        pub_close_val   = pend_close_val;
                        pub_open_turns  = pend_open_turns;
                        pub_close_turns = pend_close_turns;
                        r.store_write   = 1'b1;
                    end
                    cal_phase        = pcs_pkg::PH_END_WAIT;
                    r.blink_all_once = 1'b1;
                end
            end else begin
                r.led_one_cmd  = pcs_pkg::CMD_ALARM;
                r.led_five_cmd = pcs_pkg::CMD_ALARM;
            end
        end else if (cal_phase == pcs_pkg::PH_END_WAIT) begin
            if (!op && !cp) begin
                r.led_one_cmd     = pcs_pkg::CMD_OFF;
                r.led_five_cmd    = pcs_pkg::CMD_OFF;
                cal_on            = 1'b0;
                relays_on         = 1'b0;
                r.restart_request = 1'b1;
            end
        end
        r.relay_drive = relays_on;
        r.cal_active  = cal_on;
        r.open_value  = pub_open_val;
        r.close_value = pub_close_val;
        r.open_turns  = pub_open_turns;
        r.close_turns = pub_close_turns;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        pcs_pkg::result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.led_one_cmd     = m_tdata[2:0];
            got.led_five_cmd    = m_tdata[5:3];
            got.blink_all_once  = m_tdata[6];
            got.relay_drive     = m_tdata[7];
            got.store_write     = m_tdata[8];
            got.restart_request = m_tdata[9];
            got.cal_active      = m_tdata[10];
            got.open_value      = m_tdata[26:11];
            got.close_value     = m_tdata[42:27];
            got.open_turns      = m_tdata[58:43];
            got.close_turns     = m_tdata[74:59];
            if (expected_results.size() == 0) begin
                $error("result word with no tick waiting for it");
                errors++;
            end else begin
                want = expected_results.pop_front();
                check_field("led_one_cmd", 32'(want.led_one_cmd), 32'(got.led_one_cmd));
                check_field("led_five_cmd", 32'(want.led_five_cmd), 32'(got.led_five_cmd));
                check_field("blink_all_once", 32'(want.blink_all_once),
                            32'(got.blink_all_once));
                check_field("relay_drive", 32'(want.relay_drive), 32'(got.relay_drive));
                check_field("store_write", 32'(want.store_write), 32'(got.store_write));
                check_field("restart_request", 32'(want.restart_request),
                            32'(got.restart_request));
                check_field("cal_active", 32'(want.cal_active), 32'(got.cal_active));
                check_field("open_value", 32'(want.open_value), 32'(got.open_value));
                check_field("close_value", 32'(want.close_value), 32'(got.close_value));
                check_field("open_turns", 32'(want.open_turns), 32'(got.open_turns));
                check_field("close_turns", 32'(want.close_turns), 32'(got.close_turns));
                if (want.store_write)
                    stores_seen++;
                if (want.restart_request)
                    restarts_seen++;
                if (want.led_one_cmd == pcs_pkg::CMD_ALARM)
                    alarms_seen++;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: changing stall patterns, plus long hold-offs on request
    initial begin : receiver
        int mode, mode_left, hold_left, holds_served, step_cnt;
        mode         = 0;
        mode_left    = 0;
        hold_left    = 0;
        holds_served = 0;
        step_cnt     = 0;
        m_tready     = 1'b0;
        forever begin
            @(posedge aclk);
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 150);
                end else begin
                    mode_left--;
                end
                step_cnt++;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= ((step_cnt % 7) < 4);
                endcase
            end
        end
    end

    task automatic send_word(input bit op, input bit ol, input bit cp, input bit cl,
                             input logic [pcs_pkg::WORD_W-1:0] pos,
                             input logic [pcs_pkg::WORD_W-1:0] trn);
        logic [39:0] w;
        w = {4'b0000, trn, pos, cl, cp, ol, op};
        if (gaps_on && burst_left <= 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(predict_tick(w));
        ticks_sent++;
    endtask

    task automatic send_linear(input bit op, input bit ol, input bit cp, input bit cl,
                               input int unsigned lin);
        send_word(op, ol, cp, cl, pcs_pkg::WORD_W'(lin % REVOLUTION_SIZE),
                  pcs_pkg::WORD_W'(lin / REVOLUTION_SIZE));
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_results.size() != 0);
    endtask

    // idle ticks must not start calibration: single long presses and extremes
    task automatic test_idle_extremes();
        send_word(0, 0, 0, 0, 16'h0000, 16'h0000);
        send_word(1, 1, 1, 0, 16'hFFFF, 16'hFFFF);
        send_word(1, 0, 1, 1, 16'hFFFF, 16'h0000);
    endtask

    // endpoints captured at the all-ones reading still count as captured
    task automatic test_commit_all_ones();
        send_word(1, 1, 1, 1, 16'h0000, 16'h0000);
        send_word(1, 0, 0, 0, 16'h0000, 16'h0000);
        send_word(0, 0, 0, 0, 16'h0000, 16'h0000);
        send_word(1, 1, 0, 0, 16'hFFFF, 16'hFFFF);
        send_word(0, 0, 1, 1, 16'hFFFF, 16'hFFFF);
        send_word(1, 1, 1, 1, 16'hFFFF, 16'hFFFF);
        send_word(0, 0, 1, 0, 16'hFFFF, 16'hFFFF);
        send_word(0, 0, 0, 0, 16'hFFFF, 16'hFFFF);
    endtask

    // span of exactly one revolution alarms, commit with one endpoint does not store
    task automatic test_partial_commit_alarm();
        send_word(0, 1, 0, 1, 16'h1234, 16'h0042);
        send_word(0, 0, 0, 0, 16'h0000, 16'h0000);
        send_word(1, 1, 0, 0, 16'h0000, 16'h0000);
        send_word(0, 0, 0, 0, 16'h0000, 16'h0001);
        send_word(0, 0, 0, 0, 16'd4095, 16'h0000);
        send_word(1, 1, 1, 1, 16'd4095, 16'h0000);
        send_word(0, 0, 0, 0, 16'd4095, 16'h0000);
    endtask

    // close endpoint taken on the commit word itself, then stored; restart keeps values
    task automatic test_full_commit();
        send_word(1, 1, 1, 1, 16'h0000, 16'h0000);
        send_word(0, 0, 0, 0, 16'h0000, 16'h0000);
        send_word(1, 1, 0, 0, 16'd10, 16'd3);
        send_word(0, 0, 1, 1, 16'd4000, 16'd2);
        send_word(0, 1, 1, 1, 16'd20, 16'd3);
        send_word(0, 0, 0, 0, 16'd20, 16'd3);
    endtask

    // one well-formed session with random readings around a random base
    task automatic run_session();
        int unsigned base, lin;
        int          tries;
        bit          op, cp;
        sessions_run++;
        if ($urandom_range(0, 9) == 0)
            base = BASE_MAX - $urandom_range(0, 5000);
        else
            base = $urandom_range(0, BASE_MAX);
        op = ($urandom_range(0, 4) != 0);
        cp = ($urandom_range(0, 4) != 0);
        send_word(op, 1, cp, 1, 16'($urandom), 16'($urandom));
        repeat ($urandom_range(0, 3)) begin
            op = 1'($urandom_range(0, 1));
            cp = op ? 1'($urandom_range(0, 1)) : 1'b1;
            send_word(op, 1'($urandom_range(0, 1)), cp, 1'($urandom_range(0, 1)),
                      16'($urandom), 16'($urandom));
        end
        send_word(0, 1'($urandom_range(0, 1)), 0, 1'($urandom_range(0, 1)),
                  16'($urandom), 16'($urandom));
        repeat ($urandom_range(2, 10)) begin
            lin = base + (($urandom_range(0, 6) == 0) ? $urandom_range(0, 10000)
                                                       : $urandom_range(0, 3500));
            case ($urandom_range(0, 3))
                0: send_linear(1, 1, 0, 0, lin);
                1: send_linear(0, 0, 1, 1, lin);
                2: send_linear(0, 0, 0, 0, lin);
                default: send_linear(1, 0, 1, 0, lin);
            endcase
        end
        // retry the commit with tight endpoints while the span alarm blocks it
        tries = 0;
        while (cal_on && cal_phase == pcs_pkg::PH_CAPTURE && tries < 4) begin
            if (tries > 0) begin
                send_linear(1, 1, 0, 0, base + 100);
                send_linear(0, 0, 1, 1, base + 200);
            end
            op = ($urandom_range(0, 4) != 0);
            cp = ($urandom_range(0, 4) != 0);
            send_linear(op, 1, cp, 1, base + $urandom_range(0, 3500));
            tries++;
        end
        repeat ($urandom_range(0, 3)) begin
            op = 1'($urandom_range(0, 1));
            cp = op ? 1'($urandom_range(0, 1)) : 1'b1;
            send_word(op, 1'($urandom_range(0, 1)), cp, 1'($urandom_range(0, 1)),
                      16'($urandom), 16'($urandom));
        end
        send_word(0, 1'($urandom_range(0, 1)), 0, 1'($urandom_range(0, 1)),
                  16'($urandom), 16'($urandom));
    endtask

    task automatic send_noise_word();
        bit ol;
        ol = 1'($urandom_range(0, 1));
        send_word(1'($urandom_range(0, 1)), ol, 1'($urandom_range(0, 1)),
                  ol ? 1'b0 : 1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom));
    endtask

    // receiver holds off while the sender keeps offering, then the sender drains
    task automatic test_backpressure();
        gaps_on = 1'b0;
        hold_requests++;
        run_session();
        run_session();
        wait_results_drained();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_sessions();
        int unsigned stop_at;
        stop_at = ticks_sent + RANDOM_ITEMS;
        while (ticks_sent < stop_at) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0) begin
                // broken sequence: words of any shape
                repeat ($urandom_range(5, 15))
                    send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              16'($urandom), 16'($urandom));
            end else begin
                run_session();
                repeat ($urandom_range(0, 2)) send_noise_word();
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        clear_model();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_idle_extremes();
        test_commit_all_ones();
        test_partial_commit_alarm();
        test_full_commit();
        test_backpressure();
        test_random_sessions();
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d ticks in %0d random sessions plus directed cases", ticks_sent,
                 sessions_run);
        $display("saw %0d endpoint stores, %0d restarts and %0d span alarm ticks", stores_seen,
                 restarts_seen, alarms_seen);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/pcs_pkg.sv
design/pcs_in_stage.sv
design/pcs_ctrl.sv
design/pcs_out_stage.sv
design/position_calibration_sequencer.sv
sim/tb_position_calibration_sequencer.sv
